[hw/rtl/assert_macros.svh]
// Assertion helpers used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SBD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define SBD_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// Next-cycle implication that is also checked across reset.
`define SBD_ASSERT_NXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication across reset");

`endif

[hw/rtl/sbd_pkg.sv]
`default_nettype none

package sbd_pkg;

  localparam int unsigned TICK_W  = 16;
  localparam int unsigned STEPS_W = 5;
  localparam int unsigned LEVEL_W = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef logic [TICK_W-1:0]     tick_cnt_t;
  typedef logic [STEPS_W-1:0]    steps_t;
  typedef logic [LEVEL_W-1:0]    level_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // Register indexes on the configuration channel.
  localparam cfg_idx_t CFG_LONG_PRESS = 2'd0;
  localparam cfg_idx_t CFG_REPEAT     = 2'd1;
  localparam cfg_idx_t CFG_NUM_STEPS  = 2'd2;

  // Result action codes.
  localparam logic ACT_SET_LEVEL     = 1'b0;
  localparam logic ACT_FACTORY_RESET = 1'b1;

  // Reset values.
  localparam tick_cnt_t LONG_PRESS_RST = 16'd10000;
  localparam tick_cnt_t REPEAT_RST     = 16'd500;
  localparam steps_t    NUM_STEPS_RST  = 5'd9;
  localparam level_t    SAVED_LEVEL_RST = 4'd8;

  localparam steps_t    STEPS_MIN = 5'd2;
  localparam steps_t    STEPS_MAX = 5'd16;
  localparam tick_cnt_t HOLD_MAX  = 16'hFFFF;

endpackage

`default_nettype wire

[hw/rtl/sbd_if.sv]
`default_nettype none

interface sbd_tick_if;
  logic valid;
  logic ready;
  logic button_down;

  modport source (output valid, output button_down, input ready);
  modport sink   (input valid, input button_down, output ready);
endinterface

interface sbd_result_if;
  import sbd_pkg::*;
  logic   valid;
  logic   ready;
  logic   action;
  level_t level;
  logic   from_click;
  logic   ramp_end;

  modport source (output valid, output action, output level, output from_click,
                  output ramp_end, input ready);
  modport sink   (input valid, input action, input level, input from_click,
                  input ramp_end, output ready);
endinterface

interface sbd_cfg_if;
  import sbd_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  reg_index;
  cfg_data_t data;

  modport source (output valid, output reg_index, output data, input ready);
  modport sink   (input valid, input reg_index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/single_button_dimmer_control.sv]
// Single-button dimmer control.
// The tick channel carries one sampled button state per time tick. Each
// transfer on it advances the hold counter, the repeat timer and the dimmer
// state by one tick and produces zero or one result on the result channel:
// a new dimmer level (from a short-press toggle or a hold ramp step) or a
// factory reset request after a long press.
// The configuration channel writes long_press_ticks (index 0), repeat_ticks
// (index 1) and num_steps (index 2); it is always ready and should be used
// only while no tick is in flight.
// A result shows on the result channel in the cycle after the tick transfer
// that caused it. Throughput is one tick per cycle while the result channel
// is not stalled; the state update into the result register is combinational.
// When the receiver stalls, the result register holds its item and the tick
// channel drops ready until that result is transferred; ticks that give no
// result still need the result register free or draining.
// Synchronous reset restores the register reset values (10000, 500, 9),
// clears the other dimmer state, sets the saved level to 8 and both
// direction flags to up, and empties the result register.
`default_nettype none

module single_button_dimmer_control (
  input  wire                 clk,
  input  wire                 rst,
  sbd_tick_if.sink            tick,
  sbd_result_if.source        result,
  sbd_cfg_if.sink             cfg
);
  import sbd_pkg::*;

  // Configuration registers.
  tick_cnt_t long_press_ticks;
  tick_cnt_t repeat_ticks;
  steps_t    num_steps;

  // Dimmer state.
  logic      last_button;
  tick_cnt_t hold_count;
  logic      timer_running;
  tick_cnt_t timer_count;
  logic      short_pending;
  logic      ramping;
  level_t    step_level;
  level_t    saved_level;
  logic      dir_up;
  logic      saved_dir_up;

  // Result register.
  logic      res_valid;
  logic      res_action;
  level_t    res_level;
  logic      res_click;
  logic      res_end;

  logic      tick_fire;

  // Next-state values.
  logic      last_button_next;
  tick_cnt_t hold_count_next;
  logic      timer_running_next;
  tick_cnt_t timer_count_next;
  logic      short_pending_next;
  logic      ramping_next;
  level_t    step_level_next;
  level_t    saved_level_next;
  logic      dir_up_next;
  logic      saved_dir_up_next;

  logic      emit_next;
  logic      action_next;
  level_t    level_next;
  logic      click_next;
  logic      end_next;

  level_t    top;

  // The configuration port never stalls.
  assign cfg.ready = 1'b1;

  // A new tick is taken whenever the result register is empty or draining.
  assign tick.ready = !res_valid || result.ready;
  assign tick_fire  = tick.valid && tick.ready;

  assign result.valid      = res_valid;
  assign result.action     = res_action;
  assign result.level      = res_level;
  assign result.from_click = res_click;
  assign result.ramp_end   = res_end;

  // Top level with num_steps clamped to its legal range.
  always_comb begin
    if (num_steps < STEPS_MIN) begin
      top = level_t'(STEPS_MIN - 5'd1);
    end else if (num_steps > STEPS_MAX) begin
      top = level_t'(STEPS_MAX - 5'd1);
    end else begin
      top = level_t'(num_steps - 5'd1);
    end
  end

  // One tick of the dimmer: the button edge is handled first, then the timer.
  always_comb begin
    logic started;
    logic timer_emit;
    logic edge_emit;
    logic timer_end;
    level_t edge_level;

    started    = 1'b0;
    timer_emit = 1'b0;
    edge_emit  = 1'b0;
    timer_end  = 1'b0;
    edge_level = step_level;

    last_button_next   = last_button;
    hold_count_next    = hold_count;
    timer_running_next = timer_running;
    timer_count_next   = timer_count;
    short_pending_next = short_pending;
    ramping_next       = ramping;
    step_level_next    = step_level;
    saved_level_next   = saved_level;
    dir_up_next        = dir_up;
    saved_dir_up_next  = saved_dir_up;
    action_next        = ACT_SET_LEVEL;
    click_next         = 1'b0;
    end_next           = 1'b0;

    // The hold count advances on each tick after a pressed sample until HOLD_MAX.
    if (last_button && hold_count != HOLD_MAX) begin
      hold_count_next = hold_count + 16'd1;
    end

    if (tick.button_down != last_button) begin
      last_button_next = tick.button_down;
      if (tick.button_down) begin
        hold_count_next    = '0;
        timer_running_next = 1'b1;
        timer_count_next   = '0;
        started            = 1'b1;
        short_pending_next = 1'b1;
      end else if (hold_count_next < long_press_ticks) begin
        if (short_pending) begin
          // Short click toggles between off and the saved level.
          if (step_level == '0) begin
            step_level_next = saved_level;
            if (saved_level == '0) begin
              dir_up_next = 1'b1;
            end else if (saved_level == top) begin
              dir_up_next = 1'b0;
            end else begin
              dir_up_next = saved_dir_up;
            end
          end else begin
            saved_level_next  = step_level;
            step_level_next   = '0;
            saved_dir_up_next = dir_up;
            dir_up_next       = 1'b1;
          end
          edge_emit  = 1'b1;
          edge_level = step_level_next;
          action_next = ACT_SET_LEVEL;
          click_next  = 1'b1;
          end_next    = 1'b1;
        end else begin
          ramping_next       = 1'b0;
          timer_running_next = 1'b0;
        end
      end else begin
        // Long press released: request a factory reset.
        timer_running_next = 1'b0;
        ramping_next       = 1'b0;
        edge_emit          = 1'b1;
        action_next        = ACT_FACTORY_RESET;
        click_next         = 1'b0;
        end_next           = 1'b0;
      end
    end

    if (timer_running_next && !started) begin
      timer_count_next = timer_count + 16'd1;
      if (timer_count_next >= repeat_ticks) begin
        timer_running_next = 1'b0;
        timer_count_next   = '0;
        if (tick.button_down) begin
          ramping_next       = 1'b1;
          short_pending_next = 1'b0;
          timer_running_next = 1'b1;
        end
        if (ramping_next) begin
          timer_emit = 1'b1;
          if (dir_up_next) begin
            step_level_next  = step_level_next + 4'd1;
            saved_level_next = step_level_next;
            if (step_level_next == top) begin
              timer_running_next = 1'b0;
              dir_up_next        = 1'b0;
              timer_end          = 1'b1;
            end
          end else begin
            step_level_next = step_level_next - 4'd1;
            if (step_level_next == '0) begin
              dir_up_next        = 1'b1;
              timer_running_next = 1'b0;
              saved_level_next   = top;
              timer_end          = 1'b1;
            end else begin
              saved_level_next = step_level_next;
            end
          end
        end
      end
    end

    // An edge result wins over a timer result in the same tick.
    emit_next = edge_emit || timer_emit;
    if (edge_emit) begin
      level_next = edge_level;
    end else begin
      level_next  = step_level_next;
      action_next = ACT_SET_LEVEL;
      click_next  = 1'b0;
      end_next    = timer_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks <= LONG_PRESS_RST;
      repeat_ticks     <= REPEAT_RST;
      num_steps        <= NUM_STEPS_RST;
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        CFG_LONG_PRESS: long_press_ticks <= cfg.data;
        CFG_REPEAT:     repeat_ticks     <= cfg.data;
        CFG_NUM_STEPS:  num_steps        <= cfg.data[STEPS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_button   <= 1'b0;
      hold_count    <= '0;
      timer_running <= 1'b0;
      timer_count   <= '0;
      short_pending <= 1'b0;
      ramping       <= 1'b0;
      step_level    <= '0;
      saved_level   <= SAVED_LEVEL_RST;
      dir_up        <= 1'b1;
      saved_dir_up  <= 1'b1;
    end else if (tick_fire) begin
      last_button   <= last_button_next;
      hold_count    <= hold_count_next;
      timer_running <= timer_running_next;
      timer_count   <= timer_count_next;
      short_pending <= short_pending_next;
      ramping       <= ramping_next;
      step_level    <= step_level_next;
      saved_level   <= saved_level_next;
      dir_up        <= dir_up_next;
      saved_dir_up  <= saved_dir_up_next;
    end
  end

  // Result register: loads on a tick that produces a result, empties on transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (tick_fire) begin
      res_valid <= emit_next;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire && emit_next) begin
      res_action <= action_next;
      res_level  <= level_next;
      res_click  <= click_next;
      res_end    <= end_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/sbd_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module sbd_checker (
  input wire       clk,
  input wire       rst,
  input wire       tick_ready,
  input wire       res_valid,
  input wire       res_ready,
  input wire       res_action,
  input wire [3:0] res_level,
  input wire       res_click,
  input wire       res_end
);
  import sbd_pkg::*;

  // A stalled result holds until it is transferred.
  `SBD_ASSERT_NXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res_level) && $stable(res_action))

  // The result register is empty after reset.
  `SBD_ASSERT_NXT_ALWAYS(a_rst_empty, clk, rst, !res_valid)

  // No new tick is taken while a stalled result blocks the result register.
  `SBD_ASSERT_IMP(a_stall_blocks, clk, rst, res_valid && !res_ready, !tick_ready)

  // A factory reset request carries no click or end marker.
  `SBD_ASSERT_IMP(a_reset_fields, clk, rst, res_valid && res_action == ACT_FACTORY_RESET, !res_click && !res_end)

  // A click toggle always sets a level and marks an end.
  `SBD_ASSERT_IMP(a_click_fields, clk, rst, res_valid && res_click, res_end && res_action == ACT_SET_LEVEL)

endmodule

bind single_button_dimmer_control sbd_checker u_sbd_checker (
  .clk        (clk),
  .rst        (rst),
  .tick_ready (tick.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_action (result.action),
  .res_level  (result.level),
  .res_click  (result.from_click),
  .res_end    (result.ramp_end)
);

`default_nettype wire
